[sv/nbpa_pkg.sv]
// ----------------------------------------------------------------------------
// nbpa_pkg
// Shared constants, codes and types of the pairwise gravity acceleration core.
// ----------------------------------------------------------------------------
package nbpa_pkg;

  localparam int MAX_BODIES = 64;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  localparam int DATA_W     = 32;
  localparam int BODY_IDX_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int NUM_SHIFT  = 13;
  localparam int NUM_W      = PROD_W + NUM_SHIFT;
  localparam int DEN_W      = PROD_W;
  localparam int REM_W      = DEN_W + 1;
  localparam int CAP_BIT    = 40;
  localparam int MAG_W      = CAP_BIT + 1;
  localparam int SUM_W      = 48;
  localparam int MUL_STEPS  = MUL_B_W;
  localparam int SQRT_STEPS = MUL_A_W / 2;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOFTENING     = 1'b0,
    REG_GRAV_CONSTANT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_SOFT,
    B_RDI,
    B_LATI,
    B_RDJ,
    B_LATJ,
    B_SQX,
    B_SQY,
    B_SQZ,
    B_SQRT,
    B_DEN,
    B_PM,
    B_AXIS,
    B_NUM,
    B_DIV,
    B_NEXTJ,
    B_OUT
  } back_state_t;

endpackage

[sv/nbpa_ifs.sv]
// ----------------------------------------------------------------------------
// nbpa channel interfaces
// Body load channel, acceleration result channel and register write channel.
// ----------------------------------------------------------------------------
interface nbpa_body_if;
  import nbpa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic        [DATA_W-1:0] mass;
  logic                     last_body;
  modport source(output valid, pos_x, pos_y, pos_z, mass, last_body, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, mass, last_body, output ready);
endinterface

interface nbpa_accel_if;
  import nbpa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BODY_IDX_W-1:0]    body_index;
  logic signed [DATA_W-1:0] accel_x;
  logic signed [DATA_W-1:0] accel_y;
  logic signed [DATA_W-1:0] accel_z;
  logic                     last_result;
  modport source(output valid, body_index, accel_x, accel_y, accel_z, last_result,
                 input ready);
  modport sink(input valid, body_index, accel_x, accel_y, accel_z, last_result,
               output ready);
endinterface

interface nbpa_cfg_if;
  import nbpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/nbpa_ram.sv]
// ----------------------------------------------------------------------------
// nbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/nbpa_front.sv]
// ----------------------------------------------------------------------------
// nbpa_front
// Accepts body words, writes them to the body stores and posts a job on the
// word flagged last.
// ----------------------------------------------------------------------------
module nbpa_front (
  input  logic                      clk,
  input  logic                      rst,
  nbpa_body_if.sink                 bodies,
  input  logic                      hold,
  output logic                      wr_en,
  output logic [nbpa_pkg::IDX_W-1:0] wr_addr,
  output logic                      push,
  output logic [nbpa_pkg::CNT_W-1:0] push_n
);
  import nbpa_pkg::*;

  logic [CNT_W-1:0] loaded;
  logic             accept;
  logic             room;

  assign bodies.ready = !hold;
  assign accept       = bodies.valid && !hold;
  assign room         = loaded < CNT_W'(MAX_BODIES);
  assign wr_en        = accept && room;
  assign wr_addr      = loaded[IDX_W-1:0];
  assign push         = accept && bodies.last_body;
  // A full set ignores the body but still counts its last flag.
  assign push_n       = room ? loaded + CNT_W'(1) : loaded;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (accept) begin
      if (bodies.last_body) begin
        loaded <= '0;
      end else if (room) begin
        loaded <= loaded + CNT_W'(1);
      end
    end
  end

endmodule

[sv/nbpa_queue.sv]
// ----------------------------------------------------------------------------
// nbpa_queue
// Two-entry job queue carrying the body count of each loaded set.
// ----------------------------------------------------------------------------
module nbpa_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [nbpa_pkg::CNT_W-1:0] push_n,
  input  logic                      pop,
  output logic                      valid,
  output logic [nbpa_pkg::CNT_W-1:0] head_n
);
  import nbpa_pkg::*;

  logic [CNT_W-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       used;
  logic             do_push;
  logic             do_pop;

  assign valid   = used != 2'd0;
  assign head_n  = slot[rd_ptr];
  assign do_push = push && (used != 2'd2);
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_push) begin
        slot[wr_ptr] <= push_n;
        wr_ptr       <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      used <= used + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[sv/nbpa_arith.sv]
// ----------------------------------------------------------------------------
// nbpa_arith
// Shared iterative unit: shift-add multiply, digit-by-digit square root and
// restoring division with a capped quotient, one bit or digit per cycle.
// ----------------------------------------------------------------------------
module nbpa_arith (
  input  logic                        clk,
  input  logic                        rst,
  input  nbpa_pkg::arith_req_t        req,
  input  logic [nbpa_pkg::NUM_W-1:0]  opa,
  input  logic [nbpa_pkg::DEN_W-1:0]  opb,
  output logic                        busy,
  output logic [nbpa_pkg::PROD_W-1:0] result
);
  import nbpa_pkg::*;

  arith_op_t         op;
  logic [STEP_W-1:0] cnt;
  logic [NUM_W-1:0]  ra;
  logic [DEN_W-1:0]  rb;
  logic [REM_W-1:0]  rem;
  logic [PROD_W-1:0] res;
  logic              ovf;

  logic [PROD_W-1:0] mul_sum;
  logic [REM_W-1:0]  sq_rem;
  logic [REM_W-1:0]  sq_trial;
  logic [REM_W-1:0]  dv_rem;
  logic              dv_ge;

  assign mul_sum  = res + (rb[0] ? ra[PROD_W-1:0] : '0);
  assign sq_rem   = {rem[REM_W-3:0], ra[MUL_A_W-1:MUL_A_W-2]};
  assign sq_trial = REM_W'({res, 2'b01});
  assign dv_rem   = {rem[REM_W-2:0], ra[NUM_W-1]};
  assign dv_ge    = dv_rem >= {1'b0, rb};

  always_comb begin
    if (op == OP_DIV) begin
      result = ovf ? PROD_W'(1) << CAP_BIT : PROD_W'(res[CAP_BIT-1:0]);
    end else begin
      result = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      op   <= req.op;
      ra   <= opa;
      rb   <= opb;
      rem  <= '0;
      res  <= '0;
      ovf  <= 1'b0;
      unique case (req.op)
        OP_MUL:  cnt <= STEP_W'(MUL_STEPS - 1);
        OP_SQRT: cnt <= STEP_W'(SQRT_STEPS - 1);
        OP_DIV:  cnt <= STEP_W'(NUM_W - 1);
        default: cnt <= '0;
      endcase
    end else if (busy) begin
      unique case (op)
        OP_MUL: begin
          res <= mul_sum;
          ra  <= ra << 1;
          rb  <= rb >> 1;
        end
        OP_SQRT: begin
          ra <= ra << 2;
          if (sq_rem >= sq_trial) begin
            rem <= sq_rem - sq_trial;
            res <= {res[PROD_W-2:0], 1'b1};
          end else begin
            rem <= sq_rem;
            res <= {res[PROD_W-2:0], 1'b0};
          end
        end
        OP_DIV: begin
          ra <= ra << 1;
          if (dv_ge) begin
            rem <= dv_rem - {1'b0, rb};
            res <= {res[PROD_W-2:0], 1'b1};
            // Any quotient bit at or above the cap bit saturates the term.
            if (cnt >= STEP_W'(CAP_BIT)) begin
              ovf <= 1'b1;
            end
          end else begin
            rem <= dv_rem;
            res <= {res[PROD_W-2:0], 1'b0};
          end
        end
        default: begin
          res <= res;
        end
      endcase
      cnt <= cnt - STEP_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/nbpa_back.sv]
// ----------------------------------------------------------------------------
// nbpa_back
// Pair sequencer: walks every body pair of a job, runs each separated pair through the
// shared arithmetic unit, accumulates per-axis sums and emits one result per body.
// ----------------------------------------------------------------------------
module nbpa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  logic [nbpa_pkg::CNT_W-1:0]  job_n,
  output logic                        job_pop,
  input  logic [nbpa_pkg::DATA_W-1:0] softening,
  input  logic [nbpa_pkg::DATA_W-1:0] grav_constant,
  output logic [nbpa_pkg::IDX_W-1:0]  raddr,
  input  logic [nbpa_pkg::DATA_W-1:0] rd_x,
  input  logic [nbpa_pkg::DATA_W-1:0] rd_y,
  input  logic [nbpa_pkg::DATA_W-1:0] rd_z,
  input  logic [nbpa_pkg::DATA_W-1:0] rd_m,
  output nbpa_pkg::arith_req_t        req,
  output logic [nbpa_pkg::NUM_W-1:0]  opa,
  output logic [nbpa_pkg::DEN_W-1:0]  opb,
  input  logic                        abusy,
  input  logic [nbpa_pkg::PROD_W-1:0] ares,
  nbpa_accel_if.source                accels,
  output logic                        idle
);
  import nbpa_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0]        n;
  logic [IDX_W-1:0]        i;
  logic [IDX_W-1:0]        j;
  logic [DATA_W-1:0]       pi [AXES];
  logic [DATA_W-1:0]       pj [AXES];
  logic [DATA_W-1:0]       ud [AXES];
  logic                    neg [AXES];
  logic [DATA_W-1:0]       ud_new [AXES];
  logic                    neg_new [AXES];
  logic signed [DATA_W:0]  dd [AXES];
  logic [DATA_W-1:0]       mj;
  logic [MUL_A_W-1:0]      s;
  logic [MUL_A_W-1:0]      soft2;
  logic [MUL_A_W-1:0]      s_full;
  logic [MUL_A_W-1:0]      sq_q;
  logic [DEN_W-1:0]        den;
  logic [MUL_A_W-1:0]      p;
  logic [AXIS_W-1:0]       axis;
  logic signed [SUM_W-1:0] acc [AXES];
  logic signed [SUM_W-1:0] term;
  logic                    pair_zero;
  logic                    last_j;
  logic                    last_i;
  logic                    out_free;
  logic                    cur_zero;

  logic signed [DATA_W-1:0] sat [AXES];

  assign pj[0]     = rd_x;
  assign pj[1]     = rd_y;
  assign pj[2]     = rd_z;
  assign sq_q      = {2'b00, ares[MUL_A_W-1:2]};
  assign s_full    = s + sq_q + soft2;
  assign last_j    = (CNT_W'(j) + CNT_W'(1)) == n;
  assign last_i    = (CNT_W'(i) + CNT_W'(1)) == n;
  assign out_free  = !accels.valid || accels.ready;
  assign cur_zero  = ud[axis] == '0;
  assign idle      = state == B_IDLE;
  assign term      = neg[axis] ? -SUM_W'(ares[MAG_W-1:0]) : SUM_W'(ares[MAG_W-1:0]);

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      dd[k]      = $signed({pj[k][DATA_W-1], pj[k]}) - $signed({pi[k][DATA_W-1], pi[k]});
      neg_new[k] = dd[k][DATA_W];
      ud_new[k]  = neg_new[k] ? DATA_W'(-dd[k]) : DATA_W'(dd[k]);
      if (acc[k] > SUM_W'(32'sh7fffffff)) begin
        sat[k] = 32'sh7fffffff;
      end else if (acc[k] < -SUM_W'(33'sh080000000)) begin
        sat[k] = 32'sh80000000;
      end else begin
        sat[k] = acc[k][DATA_W-1:0];
      end
    end
    pair_zero = (ud_new[0] == '0) && (ud_new[1] == '0) && (ud_new[2] == '0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (job_valid) state_next = B_SOFT;
      B_SOFT:  if (!abusy) state_next = B_RDI;
      B_RDI:   state_next = B_LATI;
      B_LATI:  state_next = B_RDJ;
      B_RDJ:   state_next = B_LATJ;
      B_LATJ:  state_next = pair_zero ? B_NEXTJ : B_SQX;
      B_SQX:   if (!abusy) state_next = B_SQY;
      B_SQY:   if (!abusy) state_next = B_SQZ;
      B_SQZ:   if (!abusy) state_next = B_SQRT;
      B_SQRT:  if (!abusy) state_next = B_DEN;
      B_DEN:   if (!abusy) state_next = B_PM;
      B_PM:    if (!abusy) state_next = B_AXIS;
      B_AXIS: begin
        if (!cur_zero) begin
          state_next = B_NUM;
        end else if (axis == AXIS_W'(AXES - 1)) begin
          state_next = B_NEXTJ;
        end
      end
      B_NUM:   if (!abusy) state_next = B_DIV;
      B_DIV: begin
        if (!abusy) begin
          state_next = (axis == AXIS_W'(AXES - 1)) ? B_NEXTJ : B_AXIS;
        end
      end
      B_NEXTJ: state_next = last_j ? B_OUT : B_RDJ;
      B_OUT: begin
        if (out_free) begin
          state_next = last_i ? B_IDLE : B_RDI;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs: memory address, queue pop and arithmetic requests.
  always_comb begin
    raddr     = i;
    job_pop   = 1'b0;
    req.start = 1'b0;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          req.start = 1'b1;
          opa       = NUM_W'(softening);
          opb       = DEN_W'(softening);
        end
      end
      B_RDJ: raddr = j;
      B_LATJ: begin
        if (!pair_zero) begin
          req.start = 1'b1;
          opa       = NUM_W'(ud_new[0]);
          opb       = DEN_W'(ud_new[0]);
        end
      end
      B_SQX: begin
        req.start = !abusy;
        opa       = NUM_W'(ud[1]);
        opb       = DEN_W'(ud[1]);
      end
      B_SQY: begin
        req.start = !abusy;
        opa       = NUM_W'(ud[2]);
        opb       = DEN_W'(ud[2]);
      end
      B_SQZ: begin
        req.start = !abusy;
        req.op    = OP_SQRT;
        opa       = NUM_W'(s_full);
      end
      B_SQRT: begin
        req.start = !abusy;
        opa       = NUM_W'(s);
        opb       = DEN_W'(ares[MUL_B_W-1:0]);
      end
      B_DEN: begin
        req.start = !abusy;
        opa       = NUM_W'(grav_constant);
        opb       = DEN_W'(mj);
      end
      B_AXIS: begin
        req.start = !cur_zero;
        opa       = NUM_W'(p);
        opb       = DEN_W'(ud[axis]);
      end
      B_NUM: begin
        req.start = !abusy;
        req.op    = OP_DIV;
        opa       = {ares, NUM_SHIFT'(0)};
        opb       = den;
      end
      default: begin
        raddr = i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      accels.valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == B_OUT) && out_free) begin
        accels.valid <= 1'b1;
      end else if (accels.valid && accels.ready) begin
        accels.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            n <= job_n;
            i <= '0;
          end
        end
        B_SOFT: if (!abusy) soft2 <= sq_q;
        B_LATI: begin
          pi[0] <= rd_x;
          pi[1] <= rd_y;
          pi[2] <= rd_z;
          j     <= '0;
          for (int k = 0; k < AXES; k++) begin
            acc[k] <= '0;
          end
        end
        B_LATJ: begin
          ud  <= ud_new;
          neg <= neg_new;
          mj  <= rd_m;
        end
        B_SQX: if (!abusy) s <= sq_q;
        B_SQY: if (!abusy) s <= s + sq_q;
        B_SQZ: if (!abusy) s <= s_full;
        B_DEN: if (!abusy) den <= ares;
        B_PM: begin
          if (!abusy) begin
            p    <= ares[MUL_A_W-1:0];
            axis <= '0;
          end
        end
        B_AXIS: begin
          if (cur_zero && (axis != AXIS_W'(AXES - 1))) begin
            axis <= axis + AXIS_W'(1);
          end
        end
        B_DIV: begin
          if (!abusy) begin
            acc[axis] <= acc[axis] + term;
            if (axis != AXIS_W'(AXES - 1)) begin
              axis <= axis + AXIS_W'(1);
            end
          end
        end
        B_NEXTJ: j <= j + IDX_W'(1);
        B_OUT: begin
          if (out_free) begin
            accels.body_index  <= BODY_IDX_W'(i);
            accels.accel_x     <= sat[0];
            accels.accel_y     <= sat[1];
            accels.accel_z     <= sat[2];
            accels.last_result <= last_i;
            i                  <= i + IDX_W'(1);
          end
        end
        default: begin
          n <= n;
        end
      endcase
    end
  end

endmodule

[sv/nbody_pairwise_acceleration_core.sv]
// ----------------------------------------------------------------------------
// nbody_pairwise_acceleration_core
// All-pairs softened gravity in signed Q16.16 with saturated results.
// ----------------------------------------------------------------------------
// Bodies are loaded one word at a time; the word flagged last_body starts the
// computation and, after it, one acceleration word per loaded body leaves in
// load order. Every ordered pair with a nonzero separation runs through one
// shared bit-serial arithmetic unit (three squares, a square root, the
// denominator and mass products, then a multiply and a 109-step division per
// nonzero axis); coincident pairs skip the unit. Loading takes one body per
// cycle while no set is pending or running, and new bodies are taken again
// once the previous set's last result is in the output register.
module nbody_pairwise_acceleration_core (
  input  logic          clk,
  input  logic          rst,
  nbpa_body_if.sink     bodies,
  nbpa_accel_if.source  accels,
  nbpa_cfg_if.sink      cfg
);
  import nbpa_pkg::*;

  logic [DATA_W-1:0] softening;
  logic [DATA_W-1:0] grav_constant;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              push;
  logic [CNT_W-1:0]  push_n;
  logic              job_valid;
  logic [CNT_W-1:0]  job_n;
  logic              job_pop;
  logic              back_idle;
  logic              hold;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rd_x;
  logic [DATA_W-1:0] rd_y;
  logic [DATA_W-1:0] rd_z;
  logic [DATA_W-1:0] rd_m;
  arith_req_t        req;
  logic [NUM_W-1:0]  opa;
  logic [DEN_W-1:0]  opb;
  logic              abusy;
  logic [PROD_W-1:0] ares;

  assign cfg.ready = 1'b1;
  // The stores are shared, so loading waits until no set is pending or running.
  assign hold      = job_valid || !back_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      softening     <= DATA_W'(65536);
      grav_constant <= DATA_W'(65536);
    end else if (cfg.valid) begin
      if (cfg.index == REG_SOFTENING) begin
        softening <= cfg.data;
      end else begin
        grav_constant <= cfg.data;
      end
    end
  end

  nbpa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .bodies  (bodies),
    .hold    (hold),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .push    (push),
    .push_n  (push_n)
  );

  nbpa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BODIES)) u_ram_x (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(bodies.pos_x),
    .raddr(raddr), .rdata(rd_x)
  );

  nbpa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BODIES)) u_ram_y (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(bodies.pos_y),
    .raddr(raddr), .rdata(rd_y)
  );

  nbpa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BODIES)) u_ram_z (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(bodies.pos_z),
    .raddr(raddr), .rdata(rd_z)
  );

  nbpa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BODIES)) u_ram_m (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(bodies.mass),
    .raddr(raddr), .rdata(rd_m)
  );

  nbpa_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_n (push_n),
    .pop    (job_pop),
    .valid  (job_valid),
    .head_n (job_n)
  );

  nbpa_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .busy   (abusy),
    .result (ares)
  );

  nbpa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_n         (job_n),
    .job_pop       (job_pop),
    .softening     (softening),
    .grav_constant (grav_constant),
    .raddr         (raddr),
    .rd_x          (rd_x),
    .rd_y          (rd_y),
    .rd_z          (rd_z),
    .rd_m          (rd_m),
    .req           (req),
    .opa           (opa),
    .opb           (opb),
    .abusy         (abusy),
    .ares          (ares),
    .accels        (accels),
    .idle          (back_idle)
  );

endmodule

[sv/nbpa_checker.sv]
// ----------------------------------------------------------------------------
// nbpa_checker
// Port-level checks of the acceleration core, bound to the top level.
// ----------------------------------------------------------------------------
module nbpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_index,
  input logic [31:0] out_x,
  input logic        out_last
);

  // A word on the result channel stays put while it is stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_x)
                                && $stable(out_last))
    else $error("result word changed while stalled");

  // Once a set is closed, ready drops so that no further body is taken straight after it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("body taken right after the last body of a set");

  // Nothing comes out in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented straight after reset");

  // The first result of a set, if it follows straight on the previous set's last result, carries index zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid || out_index == 6'd0)
    else $error("new set does not start at index zero");

endmodule

bind nbody_pairwise_acceleration_core nbpa_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bodies.valid),
  .in_ready  (bodies.ready),
  .in_last   (bodies.last_body),
  .out_valid (accels.valid),
  .out_ready (accels.ready),
  .out_index (accels.body_index),
  .out_x     (accels.accel_x),
  .out_last  (accels.last_result)
);
